>>> src/vacancy_bitmap_row_allocator_defines.svh
// ----------------------------------------------------------------------------
// Vacancy bitmap row allocator: assertion macros
// Shared macros for the concurrent checks of the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef VACANCY_BITMAP_ROW_ALLOCATOR_DEFINES_SVH
`define VACANCY_BITMAP_ROW_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VBRA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VBRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vbra_pkg.sv
// ----------------------------------------------------------------------------
// Vacancy bitmap row allocator package
// Types, operation codes, error codes and fixed widths of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vbra_pkg;

    // Fixed field widths.
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned BIT_W     = 5;
    localparam int unsigned ROW_W     = 10;
    localparam int unsigned COUNT_W   = 11;
    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;

    // Largest row count the register can express, and the words it spans.
    localparam int unsigned MAX_COUNT = (1 << COUNT_W) - 1;
    localparam int unsigned MAX_WORDS = (1 << COUNT_W) / WORD_BITS;

    localparam logic [BIT_W-1:0]   BIT_MAX = BIT_W'(WORD_BITS - 1);
    localparam logic [COUNT_W-1:0] ROW_COUNT_RESET = COUNT_W'(1024);

    // Register map.
    localparam logic [APB_ADDR_W-1:0] ADDR_ROW_COUNT = '0;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_SET      = 2'd1,
        OP_QUERY    = 2'd2,
        OP_VALIDATE = 2'd3
    } t_opcode;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_FULL    = 2'd1;
    localparam logic [1:0] ERR_BAD_ROW = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> src/vacancy_bitmap_row_allocator.sv
// ----------------------------------------------------------------------------
// Vacancy bitmap row allocator
// First-fit row allocator over a vacancy bitmap kept in one word memory.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the slave stream: tuser carries the opcode (allocate,
//   set flag, query, validate), tdata the row, flag and allocate range.
//   Each command yields exactly one result transaction on the master stream.
//   row_count is written through the APB port; write it only while the block
//   is idle, the block itself does not enforce this. Set, query and validate
//   read one bitmap word. Allocate streams the bitmap words of its range
//   through the memory read port, one word per cycle, and stops at the first
//   vacant row or at the last word of the range, scanning at most
//   MAX_ROWS/32 words. A new command is taken only once the previous result
//   has gone to the output register. Commands rejected up front (bad row,
//   empty range) skip the bitmap read.
//   Reset marks every row vacant at once through per-word written flags, so
//   there is no clearing pass, and sets row_count to 1024.
//   A result waits in the output register while the receiver stalls; the
//   next command is still accepted and run, and only its own result waits
//   until the output register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vacancy_bitmap_row_allocator_defines.svh"

module vacancy_bitmap_row_allocator #(
    parameter int unsigned MAX_ROWS = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [vbra_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [vbra_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [vbra_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    // Command stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [9:0] row, [10] vacant_flag, [21:11] range_begin, [32:22] range_end
    input  wire logic [39:0]                        i_s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]                         i_s_tuser,
    // Result stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [0] ok, [10:1] row_id, [11] is_vacant, [13:12] error
    output logic      [15:0]                        o_m_tdata
);

    import vbra_pkg::*;

    localparam int unsigned NWORDS   = MAX_ROWS / WORD_BITS;
    localparam int unsigned DEPTH    = (NWORDS < MAX_WORDS) ? NWORDS : MAX_WORDS;
    localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LIVE_CAP = (MAX_ROWS < MAX_COUNT) ? MAX_ROWS : MAX_COUNT;

    // Command fields.
    t_opcode              w_op;
    logic [ROW_W-1:0]     w_row;
    logic                 w_vflag;
    logic [COUNT_W-1:0]   w_rb;
    logic [COUNT_W-1:0]   w_re;

    // Configuration.
    logic [COUNT_W-1:0]   r_row_count;
    logic                 w_cfg_wr;
    logic [COUNT_W-1:0]   w_live;

    // Command decode at acceptance.
    logic                 w_accept;
    logic [COUNT_W-1:0]   w_row_ext;
    logic [COUNT_W-1:0]   w_re_c;
    logic [COUNT_W-1:0]   w_re_last;
    logic                 w_row_bad;
    logic                 w_range_empty;
    logic [COUNT_W-1:0]   w_lo_row;
    logic [COUNT_W-1:0]   w_hi_row;

    // Sequencer state.
    t_state               r_state, n_state;
    t_opcode              r_op;
    logic                 r_vflag;
    logic [AW-1:0]        r_first_idx, r_last_idx;
    logic [BIT_W-1:0]     r_lo_bit, r_hi_bit;
    logic [AW-1:0]        r_rd_idx, n_rd_idx;
    logic                 r_rd_done, n_rd_done;
    logic                 r_ev_vld, n_ev_vld;
    logic [AW-1:0]        r_ev_idx;
    logic                 r_ev_fresh;

    // Bitmap memory and its written flags.
    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_mem_q;
    logic [DEPTH-1:0]     r_wvalid;
    logic                 w_rd_en;
    logic                 w_we;
    logic [WORD_BITS-1:0] w_wr_data;

    // Word evaluation.
    logic [WORD_BITS-1:0] w_word;
    logic [WORD_BITS-1:0] w_lo_mask;
    logic [WORD_BITS-1:0] w_hi_mask;
    logic [WORD_BITS-1:0] w_cand;
    logic [WORD_BITS-1:0] w_bit_mask;
    logic [BIT_W-1:0]     w_pos;
    logic                 w_found;
    logic [COUNT_W-1:0]   w_hit_row;
    logic                 w_finish;

    // Pending result and output register.
    logic                 r_res_ok, n_res_ok;
    logic [ROW_W-1:0]     r_res_row, n_res_row;
    logic                 r_res_vac, n_res_vac;
    logic [1:0]           r_res_err, n_res_err;
    logic                 r_out_vld, n_out_vld;
    logic                 w_out_load;
    logic                 r_out_ok;
    logic [ROW_W-1:0]     r_out_row;
    logic                 r_out_vac;
    logic [1:0]           r_out_err;

    // Unpack the command transaction.
    assign w_op    = t_opcode'(i_s_tuser);
    assign w_row   = i_s_tdata[9:0];
    assign w_vflag = i_s_tdata[10];
    assign w_rb    = i_s_tdata[21:11];
    assign w_re    = i_s_tdata[32:22];

    // APB register access; writes complete in the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_ROW_COUNT);
    assign prdata   = (paddr == ADDR_ROW_COUNT) ? APB_DATA_W'(r_row_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RESET;
        end else if (w_cfg_wr) begin
            r_row_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Rows in use, clamped to the capacity of the table.
    assign w_live = (r_row_count > COUNT_W'(LIVE_CAP)) ? COUNT_W'(LIVE_CAP) : r_row_count;

    // Range and row checks for a new command.
    assign o_s_tready    = (r_state == S_IDLE);
    assign w_accept      = i_s_tvalid && o_s_tready;
    assign w_row_ext     = COUNT_W'(w_row);
    assign w_re_c        = (w_re > w_live) ? w_live : w_re;
    assign w_re_last     = w_re_c - COUNT_W'(1);
    assign w_row_bad     = (w_row_ext >= w_live);
    assign w_range_empty = (w_rb >= w_re_c);
    assign w_lo_row      = (w_op == OP_ALLOC) ? w_rb : w_row_ext;
    assign w_hi_row      = (w_op == OP_ALLOC) ? w_re_last : w_row_ext;

    // The word under evaluation; a word never written reads as all vacant.
    assign w_word    = r_ev_fresh ? '1 : r_mem_q;
    assign w_lo_mask = (r_ev_idx == r_first_idx) ? ({WORD_BITS{1'b1}} << r_lo_bit) : '1;
    assign w_hi_mask = (r_ev_idx == r_last_idx) ?
                       ({WORD_BITS{1'b1}} >> (BIT_MAX - r_hi_bit)) : '1;
    assign w_cand    = w_word & w_lo_mask & w_hi_mask;
    assign w_found   = |w_cand;
    assign w_hit_row = COUNT_W'({r_ev_idx, w_pos});

    // Lowest vacant bit of the candidate word.
    always_comb begin
        w_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                w_pos = BIT_W'(i);
            end
        end
    end

    // One-hot mask of the bit that is written back.
    assign w_bit_mask = (r_op == OP_ALLOC) ? (WORD_BITS'(1) << w_pos)
                                           : (WORD_BITS'(1) << r_lo_bit);

    // Sequencer: next state, memory control and result.
    always_comb begin
        n_state   = r_state;
        n_rd_idx  = r_rd_idx;
        n_rd_done = r_rd_done;
        n_res_ok  = r_res_ok;
        n_res_row = r_res_row;
        n_res_vac = r_res_vac;
        n_res_err = r_res_err;
        w_rd_en   = 1'b0;
        w_we      = 1'b0;
        w_wr_data = w_word;
        w_finish  = 1'b0;
        w_out_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_ok  = 1'b0;
                    n_res_row = '0;
                    n_res_vac = 1'b0;
                    n_res_err = ERR_NONE;
                    n_rd_idx  = w_lo_row[BIT_W+AW-1:BIT_W];
                    n_rd_done = 1'b0;
                    if (w_op == OP_ALLOC && w_range_empty) begin
                        n_res_err = ERR_FULL;
                        n_state   = S_DONE;
                    end else if (w_op != OP_ALLOC && w_row_bad) begin
                        n_res_err = ERR_BAD_ROW;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                // Stream reads ahead of the evaluation, one word a cycle.
                w_rd_en = !r_rd_done;
                if (!r_rd_done) begin
                    n_rd_idx  = r_rd_idx + AW'(1);
                    n_rd_done = (r_rd_idx == r_last_idx);
                end
                if (r_ev_vld) begin
                    unique case (r_op)
                        OP_ALLOC: begin
                            if (w_found) begin
                                w_we      = 1'b1;
                                w_wr_data = w_word & ~w_bit_mask;
                                w_finish  = 1'b1;
                                n_res_ok  = 1'b1;
                                n_res_row = w_hit_row[ROW_W-1:0];
                            end else if (r_ev_idx == r_last_idx) begin
                                w_finish  = 1'b1;
                                n_res_err = ERR_FULL;
                            end
                        end
                        OP_SET: begin
                            w_we      = 1'b1;
                            w_wr_data = r_vflag ? (w_word | w_bit_mask)
                                                : (w_word & ~w_bit_mask);
                            w_finish  = 1'b1;
                            n_res_ok  = 1'b1;
                        end
                        OP_QUERY: begin
                            w_finish  = 1'b1;
                            n_res_ok  = 1'b1;
                            n_res_vac = w_found;
                        end
                        OP_VALIDATE: begin
                            w_finish = 1'b1;
                            if (w_found) begin
                                n_res_err = ERR_BAD_ROW;
                            end else begin
                                n_res_ok = 1'b1;
                            end
                        end
                        default: begin
                            w_finish = 1'b1;
                        end
                    endcase
                end
                if (w_finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_vld || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_ev_vld  = w_rd_en && !w_finish;
    assign n_out_vld = w_out_load || (r_out_vld && !i_m_tready);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_done <= 1'b0;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_done <= n_rd_done;
            r_ev_vld  <= n_ev_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_res_ok  <= n_res_ok;
        r_res_row <= n_res_row;
        r_res_vac <= n_res_vac;
        r_res_err <= n_res_err;
        if (w_accept) begin
            r_op        <= w_op;
            r_vflag     <= w_vflag;
            r_first_idx <= w_lo_row[BIT_W+AW-1:BIT_W];
            r_last_idx  <= w_hi_row[BIT_W+AW-1:BIT_W];
            r_lo_bit    <= w_lo_row[BIT_W-1:0];
            r_hi_bit    <= w_hi_row[BIT_W-1:0];
        end
        if (w_out_load) begin
            r_out_ok  <= r_res_ok;
            r_out_row <= r_res_row;
            r_out_vac <= r_res_vac;
            r_out_err <= r_res_err;
        end
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_ev_idx] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_mem_q    <= r_mem[r_rd_idx];
            r_ev_fresh <= !r_wvalid[r_rd_idx];
            r_ev_idx   <= r_rd_idx;
        end
    end

    // Written flags; reset makes every word read as all vacant.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (w_we) begin
            r_wvalid[r_ev_idx] <= 1'b1;
        end
    end

    // Result transaction.
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out_err, r_out_vac, r_out_row, r_out_ok};

    // Checks.
    `VBRA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        w_accept, r_state != S_IDLE, "accepted command did not start")
    `VBRA_ASSERT_NOW(a_write_on_eval, i_clk, i_rst_n,
        w_we, (r_state == S_RUN) && r_ev_vld, "bitmap write outside evaluation")
    `VBRA_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n,
        (r_state == S_RUN) && r_ev_vld, r_ev_idx <= r_last_idx, "scan past last word")
    `VBRA_ASSERT_NOW(a_ok_no_error, i_clk, i_rst_n,
        r_out_vld && r_out_ok, r_out_err == ERR_NONE, "successful result carries error")

endmodule

`default_nettype wire

>>> dv/tb_vacancy_bitmap_row_allocator.sv
// ----------------------------------------------------------------------------
// Vacancy bitmap row allocator testbench
// Drives allocate, set, query and validate commands into the stream port,
// predicts each result from a shadow copy of the vacancy bitmap and of
// row_count or from the directed table, and compares each result field
// by field. A short table of directed commands comes first, then random
// commands under several row_count settings, with random idling on both
// streams, one long stretch without idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vacancy_bitmap_row_allocator;

    import vbra_pkg::*;

    localparam int unsigned TABLE_ROWS     = 1024;
    localparam int unsigned IDLE_PCT       = 23;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PHASE_ITEMS    = 190;
    localparam int unsigned DIR_ROWS       = 27;
    localparam int unsigned NUM_PHASES     = 6;

    // One command as it enters the block.
    typedef struct packed {
        t_opcode     op;
        logic [9:0]  row;
        logic        flag;
        logic [10:0] rb;
        logic [10:0] re;
    } t_row_request;

    // One result as it leaves the block.
    typedef struct packed {
        logic       ok;
        logic [9:0] row_id;
        logic       is_vacant;
        logic [1:0] error;
    } t_row_result;

    // A directed step: either a command or a row_count write (value in re).
    typedef struct packed {
        logic        cfg;
        logic        typed;
        t_opcode     op;
        logic [9:0]  row;
        logic        flag;
        logic [10:0] rb;
        logic [10:0] re;
        logic        x_ok;
        logic [9:0]  x_row;
        logic        x_vac;
        logic [1:0]  x_err;
    } t_directed_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;

    // Shadow state of the block.
    logic        vacancy [0:TABLE_ROWS-1];
    logic [10:0] row_count_shadow;

    t_row_result pending_results [$];
    t_row_result want;

    int unsigned n_fail;
    int unsigned n_checked;
    int unsigned n_succeeded;
    int unsigned n_full;
    int unsigned n_bad_row;
    int unsigned sent_items;
    int unsigned quiet_cycles;
    int unsigned hold_left;
    logic        steady;
    logic        hold_req;

    t_directed_step dir_table [DIR_ROWS] = '{
        // Fresh table: every row vacant, row_count 1024.
        '{1'b0, 1'b1, OP_QUERY,    10'd0,    1'b0, 11'd0,    11'd0,
          1'b1, 10'd0,    1'b1, ERR_NONE},
        '{1'b0, 1'b1, OP_QUERY,    10'd1023, 1'b1, 11'd1024, 11'd0,
          1'b1, 10'd0,    1'b1, ERR_NONE},
        '{1'b0, 1'b1, OP_VALIDATE, 10'd5,    1'b0, 11'd0,    11'd0,
          1'b0, 10'd0,    1'b0, ERR_BAD_ROW},
        '{1'b0, 1'b1, OP_ALLOC,    10'd0,    1'b0, 11'd0,    11'd1024,
          1'b1, 10'd0,    1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_ALLOC,    10'd1023, 1'b1, 11'd0,    11'd1024,
          1'b1, 10'd1,    1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_ALLOC,    10'd0,    1'b0, 11'd1023, 11'd1024,
          1'b1, 10'd1023, 1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_ALLOC,    10'd0,    1'b0, 11'd1023, 11'd1024,
          1'b0, 10'd0,    1'b0, ERR_FULL},
        // Empty, inverted and past-the-end ranges.
        '{1'b0, 1'b1, OP_ALLOC,    10'd0,    1'b0, 11'd5,    11'd5,
          1'b0, 10'd0,    1'b0, ERR_FULL},
        '{1'b0, 1'b1, OP_ALLOC,    10'd0,    1'b0, 11'd1024, 11'd0,
          1'b0, 10'd0,    1'b0, ERR_FULL},
        '{1'b0, 1'b1, OP_ALLOC,    10'd0,    1'b0, 11'd1024, 11'd1024,
          1'b0, 10'd0,    1'b0, ERR_FULL},
        '{1'b0, 1'b1, OP_VALIDATE, 10'd0,    1'b1, 11'd0,    11'd1024,
          1'b1, 10'd0,    1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_VALIDATE, 10'd1023, 1'b0, 11'd0,    11'd0,
          1'b1, 10'd0,    1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_SET,      10'd0,    1'b1, 11'd0,    11'd0,
          1'b1, 10'd0,    1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_QUERY,    10'd0,    1'b0, 11'd0,    11'd0,
          1'b1, 10'd0,    1'b1, ERR_NONE},
        '{1'b0, 1'b1, OP_SET,      10'd512,  1'b0, 11'd0,    11'd0,
          1'b1, 10'd0,    1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_QUERY,    10'd512,  1'b1, 11'd0,    11'd0,
          1'b1, 10'd0,    1'b0, ERR_NONE},
        // First fit has to skip an occupied row inside one word.
        '{1'b0, 1'b0, OP_ALLOC,    10'd0,    1'b0, 11'd511,  11'd520,
          1'b0, 10'd0,    1'b0, ERR_NONE},
        '{1'b0, 1'b0, OP_ALLOC,    10'd0,    1'b0, 11'd511,  11'd520,
          1'b0, 10'd0,    1'b0, ERR_NONE},
        '{1'b0, 1'b0, OP_ALLOC,    10'd700,  1'b1, 11'd0,    11'd1024,
          1'b0, 10'd0,    1'b0, ERR_NONE},
        // Shrink the table: the range end clamps to row_count.
        '{1'b1, 1'b0, OP_ALLOC,    10'd0,    1'b0, 11'd0,    11'd40,
          1'b0, 10'd0,    1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_ALLOC,    10'd0,    1'b0, 11'd30,   11'd1024,
          1'b1, 10'd30,   1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_QUERY,    10'd40,   1'b0, 11'd0,    11'd0,
          1'b0, 10'd0,    1'b0, ERR_BAD_ROW},
        '{1'b0, 1'b1, OP_SET,      10'd1023, 1'b1, 11'd0,    11'd0,
          1'b0, 10'd0,    1'b0, ERR_BAD_ROW},
        '{1'b0, 1'b1, OP_VALIDATE, 10'd1023, 1'b0, 11'd0,    11'd0,
          1'b0, 10'd0,    1'b0, ERR_BAD_ROW},
        // No rows at all.
        '{1'b1, 1'b0, OP_ALLOC,    10'd0,    1'b0, 11'd0,    11'd0,
          1'b0, 10'd0,    1'b0, ERR_NONE},
        '{1'b0, 1'b1, OP_ALLOC,    10'd0,    1'b0, 11'd0,    11'd1024,
          1'b0, 10'd0,    1'b0, ERR_FULL},
        '{1'b0, 1'b1, OP_QUERY,    10'd0,    1'b1, 11'd0,    11'd0,
          1'b0, 10'd0,    1'b0, ERR_BAD_ROW}
    };

    logic [10:0] phase_counts [NUM_PHASES] = '{
        11'd1024, 11'd1, 11'd37, 11'd256, 11'd700, 11'd1024
    };

    vacancy_bitmap_row_allocator #(
        .MAX_ROWS(TABLE_ROWS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock with a 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Applies one command to the shadow bitmap and returns its result.
    function automatic t_row_result apply_request(input t_row_request rq);
        t_row_result res;
        int unsigned live;
        int unsigned lim;
        int unsigned r;
        logic        found;
        res   = '0;
        found = 1'b0;
        live  = (row_count_shadow < TABLE_ROWS) ? row_count_shadow : TABLE_ROWS;
        case (rq.op)
            OP_ALLOC: begin
                lim = (rq.re > live) ? live : rq.re;
                res.error = ERR_FULL;
                for (r = rq.rb; r < lim && !found; r++) begin
                    if (vacancy[r]) begin
                        vacancy[r] = 1'b0;
                        found      = 1'b1;
                        res.ok     = 1'b1;
                        res.row_id = r[9:0];
                        res.error  = ERR_NONE;
                    end
                end
            end
            OP_SET: begin
                if (rq.row >= live) begin
                    res.error = ERR_BAD_ROW;
                end else begin
                    vacancy[rq.row] = rq.flag;
                    res.ok = 1'b1;
                end
            end
            OP_QUERY: begin
                if (rq.row >= live) begin
                    res.error = ERR_BAD_ROW;
                end else begin
                    res.is_vacant = vacancy[rq.row];
                    res.ok = 1'b1;
                end
            end
            default: begin
                if (rq.row >= live || vacancy[rq.row]) begin
                    res.error = ERR_BAD_ROW;
                end else begin
                    res.ok = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    // Offers one command, waits for its transaction and records the expectation.
    task automatic issue_request(input t_row_request rq, input logic typed,
                                 input t_row_result typed_res);
        t_row_result res;
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = rq.op;
        i_s_tdata  = {7'd0, rq.re, rq.rb, rq.flag, rq.row};
        do @(posedge i_clk); while (!o_s_tready);
        res = apply_request(rq);
        pending_results.push_back(typed ? typed_res : res);
        sent_items++;
    endtask

    // Stops offering commands and waits until every result has come back.
    task automatic drain_results(input int unsigned tail_cycles);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (tail_cycles) @(posedge i_clk);
    endtask

    // Writes row_count over APB and reads it back.
    task automatic write_row_count(input logic [10:0] value);
        logic [APB_DATA_W-1:0] rd;
        drain_results(4);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_ROW_COUNT;
        pwdata  = APB_DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        row_count_shadow = value;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== APB_DATA_W'(value)) begin
            $error("row_count readback: expected %0d, actual %0d", value, rd);
            n_fail++;
        end
    endtask

    // Receiver: random stalls, a long hold-off on request, none while steady.
    initial begin
        i_m_tready = 1'b0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                hold_left  = HOLD_CYCLES - 1;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Result checker: each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no command outstanding: tdata %h", o_m_tdata);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_m_tdata[0] !== want.ok) begin
                    $error("ok: expected %0d, actual %0d", want.ok, o_m_tdata[0]);
                    n_fail++;
                end
                if (o_m_tdata[10:1] !== want.row_id) begin
                    $error("row_id: expected %0d, actual %0d", want.row_id, o_m_tdata[10:1]);
                    n_fail++;
                end
                if (o_m_tdata[11] !== want.is_vacant) begin
                    $error("is_vacant: expected %0d, actual %0d", want.is_vacant,
                           o_m_tdata[11]);
                    n_fail++;
                end
                if (o_m_tdata[13:12] !== want.error) begin
                    $error("error: expected %0d, actual %0d", want.error, o_m_tdata[13:12]);
                    n_fail++;
                end
                if (want.ok && want.error == ERR_NONE && o_m_tdata[0] === 1'b1)
                    n_succeeded++;
                if (want.error == ERR_FULL)
                    n_full++;
                if (want.error == ERR_BAD_ROW)
                    n_bad_row++;
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial begin
        t_row_request rq;
        t_row_result  typed_res;
        int unsigned  live;
        int unsigned  sel;
        int unsigned  i;
        int unsigned  p;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = OP_ALLOC;
        steady       = 1'b0;
        hold_req     = 1'b0;
        n_fail       = 0;
        n_checked    = 0;
        n_succeeded  = 0;
        n_full       = 0;
        n_bad_row    = 0;
        sent_items   = 0;
        quiet_cycles = 0;
        row_count_shadow = ROW_COUNT_RESET;
        for (i = 0; i < TABLE_ROWS; i++)
            vacancy[i] = 1'b1;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed commands and the row_count writes among them.
        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_table[i].cfg) begin
                write_row_count(dir_table[i].re);
            end else begin
                rq.op     = dir_table[i].op;
                rq.row    = dir_table[i].row;
                rq.flag   = dir_table[i].flag;
                rq.rb     = dir_table[i].rb;
                rq.re     = dir_table[i].re;
                typed_res = {dir_table[i].x_ok, dir_table[i].x_row,
                             dir_table[i].x_vac, dir_table[i].x_err};
                issue_request(rq, dir_table[i].typed, typed_res);
            end
        end

        // Random commands, one row_count setting per phase.
        for (p = 0; p < NUM_PHASES; p++) begin
            write_row_count(phase_counts[p]);
            live = (row_count_shadow < TABLE_ROWS) ? row_count_shadow : TABLE_ROWS;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                steady = (sent_items >= 400 && sent_items < 560);
                if (sent_items == 460)
                    hold_req = 1'b1;
                sel = $urandom_range(99);
                if (sel < 35)
                    rq.op = OP_ALLOC;
                else if (sel < 60)
                    rq.op = OP_SET;
                else if (sel < 80)
                    rq.op = OP_QUERY;
                else
                    rq.op = OP_VALIDATE;
                // Mostly rows inside the table, the rest anywhere.
                if (live > 0 && $urandom_range(99) < 85)
                    rq.row = 10'($urandom_range(live - 1));
                else
                    rq.row = 10'($urandom);
                rq.flag = 1'($urandom_range(1));
                // Mostly sensible ranges, some whole-table, some arbitrary.
                sel = $urandom_range(99);
                if (sel < 60) begin
                    rq.rb = 11'($urandom_range(live));
                    rq.re = 11'($urandom_range(TABLE_ROWS, rq.rb));
                end else if (sel < 75) begin
                    rq.rb = 11'd0;
                    rq.re = 11'(TABLE_ROWS);
                end else begin
                    rq.rb = 11'($urandom_range(TABLE_ROWS));
                    rq.re = 11'($urandom_range(TABLE_ROWS));
                end
                issue_request(rq, 1'b0, '0);
            end
        end
        steady = 1'b0;

        drain_results(40);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_fail++;
        end

        $display("Ran %0d commands over %0d row_count settings, %0d results checked.",
                 sent_items, NUM_PHASES + 3, n_checked);
        $display("Succeeded %0d, table-full %0d, bad row %0d.",
                 n_succeeded, n_full, n_bad_row);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
